// File: rtl/ordered_byte_set_engine_top_assert.svh
// Assertion macros for the ordered byte set engine.
`ifndef ORDERED_BYTE_SET_ENGINE_TOP_ASSERT_SVH
`define ORDERED_BYTE_SET_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OBSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define OBSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OBSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define OBSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/obse_pkg.sv
// Types and constants shared by the ordered byte set engine.
package obse_pkg;

  localparam int CMD_W  = 3;
  localparam int ELEM_W = 8;
  localparam int POS_W  = 9;
  localparam int SIZE_W = 9;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SELECT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_SELECT,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ACCESS,
    B_SCAN
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  position;
    logic              rank_zero;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [ELEM_W-1:0] element;
    logic [SIZE_W-1:0] set_size;
  } res_t;

endpackage

// File: rtl/obse_fifo.sv
// Two-entry queue that decouples the stages of the set engine.
module obse_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/obse_front.sv
// Front stage: classifies an incoming command word into an operation.
module obse_front import obse_pkg::*; (
  input  logic [CMD_W-1:0]  command_i,
  input  logic [ELEM_W-1:0] element_i,
  input  logic [POS_W-1:0]  position_i,
  output cmd_t              cmd_o
);

  always_comb begin
    cmd_o.element   = element_i;
    cmd_o.position  = position_i;
    cmd_o.rank_zero = (position_i == '0);
    case (command_i)
      CMD_INSERT: cmd_o.op = OP_INSERT;
      CMD_DELETE: cmd_o.op = OP_DELETE;
      CMD_SEARCH: cmd_o.op = OP_SEARCH;
      CMD_SELECT: cmd_o.op = OP_SELECT;
      CMD_CLEAR:  cmd_o.op = OP_CLEAR;
      default:    cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/obse_back.sv
// Back stage: presence map memory, member count and the command sequencer.
`include "ordered_byte_set_engine_top_assert.svh"
module obse_back import obse_pkg::*; #(
  parameter int ELEMENT_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int ROW_LOG  = ELEMENT_BITS / 2;
  localparam int ROW_BITS = 1 << ROW_LOG;
  localparam int ADDR_W   = ELEMENT_BITS - ROW_LOG;
  localparam int NUM_ROWS = 1 << ADDR_W;
  localparam int CNT_W    = ELEMENT_BITS + 1;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int POP_W    = ROW_LOG + 1;

  back_state_e state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CMP_W-1:0]    rem_q, rem_d;
  logic [ADDR_W-1:0]   chk_ptr_q, chk_ptr_d;
  logic [NUM_ROWS-1:0] row_vld_q;
  logic [ROW_BITS-1:0] mem [NUM_ROWS];
  logic [ROW_BITS-1:0] rdata_q;
  logic                rvld_q;

  logic [ADDR_W-1:0]       raddr;
  logic                    we;
  logic [ROW_BITS-1:0]     wdata;
  logic                    clr_all;
  logic [ROW_BITS-1:0]     row;
  logic [POP_W-1:0]        pop;
  logic [ROW_LOG-1:0]      hit_idx;
  logic [ELEMENT_BITS-1:0] elem_in;
  logic [ELEMENT_BITS-1:0] elem_cur;
  logic [ADDR_W-1:0]       cur_row;
  logic [ROW_LOG-1:0]      cur_bit;
  logic [ROW_BITS-1:0]     cur_mask;
  logic                    cur_hit;
  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        pop_ext;
  logic                    room_ok;
  logic                    scan_last;
  logic                    scan_hit;
  logic                    clear_taken;
  logic                    set_empty;
  logic                    insert_new;
  logic                    count_grows;

  assign row      = rvld_q ? rdata_q : '0;
  assign pop      = POP_W'($countones(row));
  assign pop_ext  = CMP_W'(pop);
  assign elem_in  = ELEMENT_BITS'(cmd_i.element);
  assign elem_cur = ELEMENT_BITS'(cur_q.element);
  assign cur_row  = elem_cur[ELEMENT_BITS-1:ROW_LOG];
  assign cur_bit  = elem_cur[ROW_LOG-1:0];
  assign cur_mask = ROW_BITS'(1) << cur_bit;
  assign cur_hit  = row[cur_bit];
  assign pos_ext  = CMP_W'(cmd_i.position);

  assign room_ok     = cmd_valid_i && !res_full_i;
  assign scan_last   = (state_q == B_SCAN) && (chk_ptr_q == ADDR_W'(NUM_ROWS - 1));
  assign scan_hit    = (rem_q <= pop_ext);
  assign clear_taken = cmd_pop_o && (cmd_i.op == OP_CLEAR);
  assign set_empty   = (count_q == '0) && (row_vld_q == '0);
  assign insert_new  = (state_q == B_ACCESS) && (cur_q.op == OP_INSERT) && !cur_hit;
  assign count_grows = (count_d == count_q + CNT_W'(1));

  // Locates the set bit whose inclusive prefix count equals the remaining rank.
  always_comb begin
    logic [ROW_BITS-1:0] pmask;
    logic [CMP_W-1:0]    pre;
    hit_idx = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      pmask = {ROW_BITS{1'b1}} >> (ROW_BITS - 1 - i);
      pre   = CMP_W'($countones(row & pmask));
      if (row[i] && (pre == rem_q)) begin
        hit_idx = ROW_LOG'(i);
      end
    end
  end

  always_comb begin
    state_d        = state_q;
    cur_d          = cur_q;
    count_d        = count_q;
    rem_d          = rem_q;
    chk_ptr_d      = chk_ptr_q;
    raddr          = chk_ptr_q + ADDR_W'(1);
    we             = 1'b0;
    wdata          = row;
    clr_all        = 1'b0;
    cmd_pop_o      = 1'b0;
    res_push_o     = 1'b0;
    res_o.status   = ST_OK;
    res_o.found    = 1'b0;
    res_o.element  = '0;
    case (state_q)
      B_IDLE: begin
        raddr = elem_in[ELEMENT_BITS-1:ROW_LOG];
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          case (cmd_i.op)
            OP_INSERT, OP_DELETE, OP_SEARCH: begin
              state_d = B_ACCESS;
            end
            OP_SELECT: begin
              if (cmd_i.rank_zero || (pos_ext > CMP_W'(count_q))) begin
                res_push_o   = 1'b1;
                res_o.status = ST_ABSENT;
              end else begin
                raddr     = '0;
                chk_ptr_d = '0;
                rem_d     = pos_ext;
                state_d   = B_SCAN;
              end
            end
            OP_CLEAR: begin
              clr_all    = 1'b1;
              count_d    = '0;
              res_push_o = 1'b1;
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      B_ACCESS: begin
        res_push_o = 1'b1;
        state_d    = B_IDLE;
        case (cur_q.op)
          OP_INSERT: begin
            if (cur_hit) begin
              res_o.status = ST_PRESENT;
            end else begin
              we      = 1'b1;
              wdata   = row | cur_mask;
              count_d = count_q + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            if (!cur_hit) begin
              res_o.status = ST_ABSENT;
            end else begin
              we      = 1'b1;
              wdata   = row & ~cur_mask;
              count_d = count_q - CNT_W'(1);
            end
          end
          OP_SEARCH: begin
            res_o.found = cur_hit;
          end
          default: begin
          end
        endcase
      end
      B_SCAN: begin
        if (rem_q <= pop_ext) begin
          res_push_o    = 1'b1;
          res_o.found   = 1'b1;
          res_o.element = ELEM_W'({chk_ptr_q, hit_idx});
          state_d       = B_IDLE;
        end else begin
          rem_d     = rem_q - pop_ext;
          chk_ptr_d = chk_ptr_q + ADDR_W'(1);
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
    res_o.set_size = SIZE_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      count_q   <= '0;
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rvld_q  <= row_vld_q[raddr];
      if (clr_all) begin
        row_vld_q <= '0;
      end else if (we) begin
        row_vld_q[cur_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rem_q     <= rem_d;
    chk_ptr_q <= chk_ptr_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cur_row] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  `OBSE_ASSERT_IMPLY(a_pop_room, clk_i, rst_ni, cmd_pop_o, room_ok, "Command taken without room.")
  `OBSE_ASSERT_IMPLY(a_scan_bound, clk_i, rst_ni, scan_last, scan_hit, "Select ran past the map.")
  `OBSE_ASSERT_NEXT(a_clear_count, clk_i, rst_ni, clear_taken, set_empty, "Clear left members.")
  `OBSE_ASSERT_IMPLY(a_insert_count, clk_i, rst_ni, insert_new, count_grows, "Insert kept count.")

endmodule

// File: rtl/ordered_byte_set_engine_top.sv
// Top level of the ordered byte set engine.
//
// Command words enter through a queue-style port: a word is taken at a
// rising edge where push is high and full is low. Each word carries a
// command, an element and a 1-based select position. Every command gives
// exactly one result word, read through a second queue-style port: the
// oldest result shows on the result ports while empty is low and leaves at
// an edge where pop is high.
// Insert, delete and search pass through the idle and access states of
// the back stage; clear, an unused command or a select with a bad position
// is answered from the idle state. A valid select walks the map one row
// per cycle, up to 16 rows with the default element width; the row read
// port sets that pace.
// Two-entry queues stand before and after the back stage, so commands are
// still taken while results wait. When the receiver stalls, the result
// queue fills, the back stage holds, and full rises once the command queue
// fills as well.
// Reset empties the set, the count and both queues at once.
module ordered_byte_set_engine_top import obse_pkg::*; #(
  parameter int ELEMENT_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [ELEM_W-1:0] element_i,
  input  logic [POS_W-1:0]  position_i,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status_o,
  output logic              found_o,
  output logic [ELEM_W-1:0] result_element_o,
  output logic [SIZE_W-1:0] set_size_o
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t back_res;
  res_t out_res;

  obse_front u_front (
    .command_i  (command_i),
    .element_i  (element_i),
    .position_i (position_i),
    .cmd_o      (front_cmd)
  );

  obse_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  obse_back #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  obse_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign status_o         = out_res.status;
  assign found_o          = out_res.found;
  assign result_element_o = out_res.element;
  assign set_size_o       = out_res.set_size;

endmodule

// File: dv/ordered_byte_set_engine_top_tb.sv
// Self-checking testbench for the ordered byte set engine.
module ordered_byte_set_engine_top_tb;
  import obse_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int MAP_SIZE = 1 << ELEM_W;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ELEM_W-1:0] elem;
    logic [POS_W-1:0]  pos;
  } set_cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [CMD_W-1:0]  command_i = '0;
  logic [ELEM_W-1:0] element_i = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        status_o;
  logic              found_o;
  logic [ELEM_W-1:0] result_element_o;
  logic [SIZE_W-1:0] set_size_o;

  set_cmd_t pending_cmds[$];
  res_t     expected_results[$];

  logic [MAP_SIZE-1:0] member_map = '0;
  logic [SIZE_W-1:0]   member_count = '0;

  int total_cmds = 0;
  int cmds_taken = 0;
  int error_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit pause_done = 1'b0;

  ordered_byte_set_engine_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .element_i       (element_i),
    .position_i      (position_i),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .found_o         (found_o),
    .result_element_o(result_element_o),
    .set_size_o      (set_size_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one command to the shadow set and returns the word it should produce.
  function automatic res_t set_apply(logic [CMD_W-1:0] cmd, logic [ELEM_W-1:0] elem,
                                     logic [POS_W-1:0] pos);
    res_t r;
    int   seen;
    r = '0;
    seen = 0;
    case (cmd)
      CMD_INSERT: begin
        if (member_map[elem]) begin
          r.status = ST_PRESENT;
        end else begin
          member_map[elem] = 1'b1;
          member_count = member_count + SIZE_W'(1);
        end
      end
      CMD_DELETE: begin
        if (!member_map[elem]) begin
          r.status = ST_ABSENT;
        end else begin
          member_map[elem] = 1'b0;
          member_count = member_count - SIZE_W'(1);
        end
      end
      CMD_SEARCH: r.found = member_map[elem];
      CMD_SELECT: begin
        if (pos == 0 || pos > member_count) begin
          r.status = ST_ABSENT;
        end else begin
          r.found = 1'b1;
          for (int v = 0; v < MAP_SIZE; v++) begin
            if (member_map[v]) begin
              seen++;
              if (seen == int'(pos)) begin
                r.element = ELEM_W'(v);
                break;
              end
            end
          end
        end
      end
      CMD_CLEAR: begin
        member_map = '0;
        member_count = '0;
      end
      default: ;
    endcase
    r.set_size = member_count;
    return r;
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [ELEM_W-1:0] elem,
                         logic [POS_W-1:0] pos);
    set_cmd_t c;
    c.cmd = cmd;
    c.elem = elem;
    c.pos = pos;
    pending_cmds.push_back(c);
    void'(set_apply(cmd, elem, pos));
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int sender_idle_pct();
    if (cmds_taken < total_cmds / 3) return 6;
    else if (cmds_taken < 2 * total_cmds / 3) return 73;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (cmds_taken < total_cmds / 3) return 73;
    else if (cmds_taken < 2 * total_cmds / 3) return 6;
    return 0;
  endfunction

  always @(negedge clk_i) begin : drive_cmds
    logic go;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      go = pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct();
      if (cmds_taken == total_cmds / 2 && !pause_done) begin
        if (expected_results.size() == 0) pause_done = 1'b1;
        else go = 1'b0;
      end
      push <= go;
      if (go) begin
        command_i <= pending_cmds[0].cmd;
        element_i <= pending_cmds[0].elem;
        position_i <= pending_cmds[0].pos;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (!hold_done && cmds_taken >= 2 * total_cmds / 3 + 30) begin
      hold_done = 1'b1;
      hold_left = 80;
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(0, 99) >= receiver_idle_pct();
    end
  end

  always @(posedge clk_i) begin : watch_results
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no command waiting for it");
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (found_o !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", found_o, want.found));
          if (result_element_o !== want.element)
            report_mismatch($sformatf("element %0d, expected %0d", result_element_o,
                                      want.element));
          if (set_size_o !== want.set_size)
            report_mismatch($sformatf("set size %0d, expected %0d", set_size_o,
                                      want.set_size));
        end
      end
      if (push && !full) begin
        expected_results.push_back(set_apply(command_i, element_i, position_i));
        pending_cmds.delete(0);
        cmds_taken++;
      end
    end
  end

  initial begin
    int perm[MAP_SIZE];
    int i;
    int k;
    int tmp;
    int j;
    res_t pick;

    add_cmd(CMD_SEARCH, 8'd0, 9'd0);
    add_cmd(CMD_SELECT, 8'hFF, 9'd1);
    add_cmd(CMD_DELETE, 8'd0, 9'h1FF);
    add_cmd(CMD_INSERT, 8'd0, 9'd0);
    add_cmd(CMD_INSERT, 8'hFF, 9'd0);
    add_cmd(CMD_INSERT, 8'd0, 9'd0);
    add_cmd(CMD_INSERT, 8'd128, 9'd0);
    add_cmd(CMD_SEARCH, 8'hFF, 9'd0);
    add_cmd(CMD_SEARCH, 8'd127, 9'd0);
    add_cmd(CMD_SELECT, 8'd0, 9'd0);
    add_cmd(CMD_SELECT, 8'd0, 9'd1);
    add_cmd(CMD_SELECT, 8'hFF, 9'd3);
    add_cmd(CMD_SELECT, 8'd0, 9'd4);
    add_cmd(CMD_SELECT, 8'd0, 9'h1FF);
    add_cmd(CMD_SELECT, 8'd0, 9'd256);
    add_cmd(CMD_DELETE, 8'd128, 9'd0);
    add_cmd(CMD_DELETE, 8'd128, 9'd0);
    add_cmd(CMD_UNUSED_FIRST, 8'hFF, 9'h1FF);
    add_cmd(CMD_UNUSED_FIRST + 3'd1, 8'h55, 9'd1);
    add_cmd(CMD_UNUSED_LAST, 8'hAA, 9'd2);
    add_cmd(CMD_CLEAR, 8'hFF, 9'h1FF);
    add_cmd(CMD_SELECT, 8'd0, 9'd1);
    add_cmd(CMD_INSERT, 8'hAA, 9'd0);
    add_cmd(CMD_INSERT, 8'h55, 9'd0);
    add_cmd(CMD_CLEAR, 8'd0, 9'd0);

    for (i = 0; i < MAP_SIZE; i++) perm[i] = i;
    for (i = MAP_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (i = 0; i < MAP_SIZE; i++) begin
      add_cmd(CMD_INSERT, ELEM_W'(perm[i]), POS_W'($urandom));
      case ($urandom_range(0, 7))
        0: add_cmd(CMD_SELECT, ELEM_W'($urandom), POS_W'($urandom_range(0, member_count + 1)));
        1: add_cmd(CMD_SEARCH, ELEM_W'($urandom), POS_W'($urandom));
        2: add_cmd(CMD_INSERT, ELEM_W'(perm[$urandom_range(0, i)]), POS_W'($urandom));
        default: ;
      endcase
    end
    add_cmd(CMD_SELECT, 8'd0, 9'd256);
    add_cmd(CMD_SELECT, 8'd0, 9'd257);
    add_cmd(CMD_SELECT, 8'd0, 9'd1);
    add_cmd(CMD_INSERT, ELEM_W'($urandom), 9'd0);

    for (i = 0; i < 300; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25) begin
        add_cmd(CMD_INSERT, ELEM_W'($urandom), POS_W'($urandom));
      end else if (k < 50) begin
        if (member_count != 0 && $urandom_range(0, 1) == 1) begin
          pick = set_apply(CMD_SELECT, '0, POS_W'($urandom_range(1, member_count)));
          add_cmd(CMD_DELETE, pick.element, POS_W'($urandom));
        end else begin
          add_cmd(CMD_DELETE, ELEM_W'($urandom), POS_W'($urandom));
        end
      end else if (k < 62) begin
        add_cmd(CMD_SEARCH, ELEM_W'($urandom), POS_W'($urandom));
      end else if (k < 95) begin
        if (member_count != 0 && $urandom_range(0, 99) < 80)
          add_cmd(CMD_SELECT, ELEM_W'($urandom), POS_W'($urandom_range(1, member_count)));
        else
          add_cmd(CMD_SELECT, ELEM_W'($urandom), POS_W'($urandom_range(0, 511)));
      end else if (k < 96) begin
        add_cmd(CMD_CLEAR, ELEM_W'($urandom), POS_W'($urandom));
      end else begin
        add_cmd(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                ELEM_W'($urandom), POS_W'($urandom));
      end
    end

    for (i = 0; i < 80; i++) begin
      k = $urandom_range(CMD_INSERT, CMD_CLEAR + 3);
      if (k > CMD_CLEAR) k = int'(CMD_INSERT);
      add_cmd(CMD_W'(k), ELEM_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 18)));
    end

    total_cmds = pending_cmds.size();
    member_map = '0;
    member_count = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/obse_pkg.sv
rtl/obse_fifo.sv
rtl/obse_front.sv
rtl/obse_back.sv
rtl/ordered_byte_set_engine_top.sv
dv/ordered_byte_set_engine_top_tb.sv
